// ===== rtl/text_console_cursor_scroll_macros.svh =====
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared property shorthands for the console's checkers.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define TCCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define TCCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Request codes, register indexes, command and response types, defaults.
// ----------------------------------------------------------------------------
package tccs_pkg;

   // Default geometry
   localparam int DEF_COLS       = 32;
   localparam int DEF_ROWS       = 24;
   localparam int DEF_ROW_STRIDE = 32;

   // Depth of the command and response queues
   localparam int QUEUE_DEPTH = 2;

   // Widest screen coordinate the geometry range allows (0 .. 63)
   localparam int COORD_W = 6;

   // Request type codes on req_type
   localparam logic [2:0] REQ_PUT_CURSOR = 3'd0;
   localparam logic [2:0] REQ_PUT_POS    = 3'd1;
   localparam logic [2:0] REQ_CLEAR      = 3'd2;
   localparam logic [2:0] REQ_HOME       = 3'd3;
   localparam logic [2:0] REQ_READ       = 3'd4;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_SPACE_GLYPH = 2'd0;
   localparam logic [1:0] CSR_FIRST_CODE  = 2'd1;
   localparam logic [1:0] CSR_GLYPH_COUNT = 2'd2;

   // Reset values of the registers
   localparam logic [7:0] RST_SPACE_GLYPH = 8'd0;
   localparam logic [7:0] RST_FIRST_CODE  = 8'd32;
   localparam logic [8:0] RST_GLYPH_COUNT = 9'd96;

   // Control characters
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_RETURN  = 8'h0D;

   // Decoded command codes passed from front to back
   localparam logic [2:0] CMD_NOP   = 3'd0;
   localparam logic [2:0] CMD_CHAR  = 3'd1;
   localparam logic [2:0] CMD_NL    = 3'd2;
   localparam logic [2:0] CMD_CR    = 3'd3;
   localparam logic [2:0] CMD_PUT   = 3'd4;
   localparam logic [2:0] CMD_CLEAR = 3'd5;
   localparam logic [2:0] CMD_HOME  = 3'd6;
   localparam logic [2:0] CMD_READ  = 3'd7;

   typedef struct packed {
      logic [2:0]         op;
      logic [7:0]         glyph;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic [7:0] read_glyph;
      logic [4:0] cursor_col;
      logic [4:0] cursor_row;
      logic       did_scroll;
   } rsp_type;

endpackage

// ===== rtl/tccs_fifo.sv =====
// ----------------------------------------------------------------------------
// Text console queue
// Small first-in first-out buffer of flat words, used between the parts.
// ----------------------------------------------------------------------------
module tccs_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  logic [W-1:0] wr_data,
   input  logic         rd_en,
   output logic [W-1:0] rd_data,
   output logic         full,
   output logic         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW:0]   DEPTH_C = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   logic [W-1:0]  store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_wr, do_rd;

   assign full    = (count_ff == DEPTH_C);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the payload words
   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/tccs_front.sv =====
// ----------------------------------------------------------------------------
// Text console front end
// Classifies each request, maps its character to a glyph and checks range.
// ----------------------------------------------------------------------------
module tccs_front import tccs_pkg::*; #(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  logic        [2:0] req_type,
   input  logic        [7:0] req_char_code,
   input  logic signed [6:0] req_pos_col,
   input  logic signed [6:0] req_pos_row,
   input  logic        [7:0] space_glyph,
   input  logic        [7:0] first_code,
   input  logic        [8:0] glyph_count,
   output cmd_type           cmd
);

   localparam logic [6:0] COLS_LIM = 7'(COLS);
   localparam logic [6:0] ROWS_LIM = 7'(ROWS);

   logic [7:0] code_diff;
   logic       in_font;
   logic [7:0] glyph;
   logic       on_screen;

   // Map the character code onto the font
   assign code_diff = req_char_code - first_code;
   assign in_font   = (req_char_code >= first_code) && ({1'b0, code_diff} < glyph_count);
   assign glyph     = in_font ? code_diff : space_glyph;

   // Check the requested position against the screen
   assign on_screen = !req_pos_col[6] && ({1'b0, req_pos_col[5:0]} < COLS_LIM)
                   && !req_pos_row[6] && ({1'b0, req_pos_row[5:0]} < ROWS_LIM);

   // Classify the transaction
   always_comb begin
      cmd.op    = CMD_NOP;
      cmd.glyph = glyph;
      cmd.col   = COORD_W'(req_pos_col[5:0]);
      cmd.row   = COORD_W'(req_pos_row[5:0]);
      case (req_type)
         REQ_PUT_CURSOR: begin
            if (req_char_code == CHR_NEWLINE) begin
               cmd.op = CMD_NL;
            end else if (req_char_code == CHR_RETURN) begin
               cmd.op = CMD_CR;
            end else begin
               cmd.op = CMD_CHAR;
            end
         end
         REQ_PUT_POS: begin
            cmd.op = on_screen ? CMD_PUT : CMD_NOP;
         end
         REQ_CLEAR: begin
            cmd.op = CMD_CLEAR;
         end
         REQ_HOME: begin
            cmd.op = CMD_HOME;
         end
         REQ_READ: begin
            cmd.op = on_screen ? CMD_READ : CMD_NOP;
         end
         default: begin
            cmd.op = CMD_NOP;
         end
      endcase
   end

endmodule

// ===== rtl/tccs_back.sv =====
// ----------------------------------------------------------------------------
// Text console back end
// Executes commands on the cell memory, cursor and top-row offset.
// ----------------------------------------------------------------------------
module tccs_back import tccs_pkg::*; #(
   parameter int COLS       = DEF_COLS,
   parameter int ROWS       = DEF_ROWS,
   parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       res_full,
   output logic       res_push,
   output rsp_type    res,
   input  logic [7:0] space_glyph,
   output logic       init_busy
);

   localparam int PITCH = (ROW_STRIDE > COLS) ? ROW_STRIDE : COLS;
   localparam int CELLS = ROWS * PITCH;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);
   localparam logic [AW-1:0] PITCH_A   = AW'(PITCH);
   localparam logic [AW-1:0] COL_SPAN  = AW'(COLS - 1);
   localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

   // Sequencer states
   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_FILL = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] line_ff, line_in;
   logic [RW-1:0] top_ff, top_in;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [AW-1:0] fill_end_ff, fill_end_in;
   logic [7:0]    fill_val_ff, fill_val_in;

   logic [7:0]    mem [CELLS];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic [AW-1:0] cur_addr;
   logic [AW-1:0] pos_addr;
   logic [AW-1:0] top_base;
   logic          nl_req;
   logic          scrolled;
   logic [7:0]    rd_glyph;

   // Physical address of a screen cell behind the circular top row
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                               input logic [RW-1:0] r,
                                               input logic [RW-1:0] t);
      logic [RW:0]   sum;
      logic [RW-1:0] phys;
      sum = {1'b0, t} + {1'b0, r};
      if (sum >= ROWS_W) begin
         phys = RW'(sum - ROWS_W);
      end else begin
         phys = sum[RW-1:0];
      end
      return AW'(AW'(phys) * PITCH_A) + AW'(c);
   endfunction

   assign cur_addr  = cell_addr(col_ff, line_ff, top_ff);
   assign pos_addr  = cell_addr(cmd.col[CW-1:0], cmd.row[RW-1:0], top_ff);
   assign top_base  = AW'(AW'(top_ff) * PITCH_A);
   assign init_busy = (state_ff == S_INIT);
   assign mem_raddr = pos_addr;

   // Sequence commands, fills and reads
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_end_in  = fill_end_ff;
      fill_val_in  = fill_val_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = fill_val_ff;
      cmd_pop      = 1'b0;
      res_push     = 1'b0;
      nl_req       = 1'b0;
      scrolled     = 1'b0;
      rd_glyph     = 8'd0;
      case (state_ff)
         S_INIT, S_FILL: begin
            mem_we = 1'b1;
            if (fill_addr_ff == fill_end_ff) begin
               state_in = S_RUN;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         S_READ: begin
            res_push = 1'b1;
            rd_glyph = rd_data_ff;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (cmd_valid && !res_full) begin
               cmd_pop  = 1'b1;
               res_push = (cmd.op != CMD_READ);
               case (cmd.op)
                  CMD_CHAR: begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_addr;
                     mem_wdata = cmd.glyph;
                     if (col_ff == COL_LAST) begin
                        nl_req = 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  CMD_NL: begin
                     nl_req = 1'b1;
                  end
                  CMD_CR: begin
                     col_in = '0;
                  end
                  CMD_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_addr;
                     mem_wdata = cmd.glyph;
                  end
                  CMD_CLEAR: begin
                     col_in       = '0;
                     line_in      = '0;
                     top_in       = '0;
                     fill_addr_in = '0;
                     fill_end_in  = CELL_LAST;
                     fill_val_in  = space_glyph;
                     state_in     = S_FILL;
                  end
                  CMD_HOME: begin
                     col_in  = '0;
                     line_in = '0;
                  end
                  CMD_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     col_in = col_ff;
                  end
               endcase
               // Take a new line, scrolling from the last row
               if (nl_req) begin
                  col_in = '0;
                  if (line_ff == ROW_LAST) begin
                     scrolled     = 1'b1;
                     top_in       = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
                     fill_addr_in = top_base;
                     fill_end_in  = top_base + COL_SPAN;
                     fill_val_in  = space_glyph;
                     state_in     = S_FILL;
                  end else begin
                     line_in = line_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
      res.read_glyph = rd_glyph;
      res.cursor_col = 5'(col_in);
      res.cursor_row = 5'(line_in);
      res.did_scroll = scrolled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         fill_addr_ff <= '0;
         fill_end_ff  <= CELL_LAST;
         fill_val_ff  <= 8'd0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_end_ff  <= fill_end_in;
         fill_val_ff  <= fill_val_in;
      end
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Character-cell screen store with a cursor and a circular top-row offset.
// ----------------------------------------------------------------------------
// Each request yields one response. Cursor puts, carriage returns, newlines
// without scroll, home, positioned puts and ignored requests complete in the
// back end straight from the run state; a cell read also passes through the
// read state, as the cell memory has a registered read. A scroll holds the back
// end while it blanks one physical row, and a clear while it fills the whole
// memory one cell a cycle. After reset, full stays high while a clearing pass
// zeroes the memory; CSR writes are taken throughout. A two-entry command queue
// and a two-entry response queue decouple the back end from both sides, so
// requests keep being taken while a scroll or clear fill runs or a response
// waits.
module text_console_cursor_scroll import tccs_pkg::*; #(
   parameter int COLS       = DEF_COLS,
   parameter int ROWS       = DEF_ROWS,
   parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic        [2:0] req_type,
   input  logic        [7:0] req_char_code,
   input  logic signed [6:0] req_pos_col,
   input  logic signed [6:0] req_pos_row,
   output logic              empty,
   input  logic              pop,
   output logic        [7:0] rsp_read_glyph,
   output logic        [4:0] rsp_cursor_col,
   output logic        [4:0] rsp_cursor_row,
   output logic              rsp_did_scroll,
   input  logic              csr_wr_en,
   input  logic        [1:0] csr_index,
   input  logic        [8:0] csr_wdata
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [7:0] space_glyph_ff;
   logic [7:0] first_code_ff;
   logic [8:0] glyph_count_ff;

   cmd_type    front_cmd;
   cmd_type    back_cmd;
   logic [CMD_W-1:0] back_cmd_bits;
   logic       cmd_full, cmd_empty, cmd_pop;
   logic       init_busy;
   rsp_type    back_res;
   rsp_type    out_res;
   logic [RSP_W-1:0] out_res_bits;
   logic       res_full, res_push;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         space_glyph_ff <= RST_SPACE_GLYPH;
         first_code_ff  <= RST_FIRST_CODE;
         glyph_count_ff <= RST_GLYPH_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SPACE_GLYPH: space_glyph_ff <= csr_wdata[7:0];
            CSR_FIRST_CODE:  first_code_ff  <= csr_wdata[7:0];
            CSR_GLYPH_COUNT: glyph_count_ff <= csr_wdata;
            default: begin
               space_glyph_ff <= space_glyph_ff;
            end
         endcase
      end
   end

   // Classify incoming transactions
   tccs_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_pos_col   (req_pos_col),
      .req_pos_row   (req_pos_row),
      .space_glyph   (space_glyph_ff),
      .first_code    (first_code_ff),
      .glyph_count   (glyph_count_ff),
      .cmd           (front_cmd)
   );

   assign full = cmd_full || init_busy;

   // Queue commands between front and back
   tccs_fifo #(
      .W     (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && !full),
      .wr_data (front_cmd),
      .rd_en   (cmd_pop),
      .rd_data (back_cmd_bits),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   assign back_cmd = cmd_type'(back_cmd_bits);

   // Carry out commands on the screen
   tccs_back #(
      .COLS       (COLS),
      .ROWS       (ROWS),
      .ROW_STRIDE (ROW_STRIDE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!cmd_empty),
      .cmd         (back_cmd),
      .cmd_pop     (cmd_pop),
      .res_full    (res_full),
      .res_push    (res_push),
      .res         (back_res),
      .space_glyph (space_glyph_ff),
      .init_busy   (init_busy)
   );

   // Queue responses towards the consumer
   tccs_fifo #(
      .W     (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (back_res),
      .rd_en   (pop),
      .rd_data (out_res_bits),
      .full    (res_full),
      .empty   (empty)
   );

   assign out_res        = rsp_type'(out_res_bits);
   assign rsp_read_glyph = out_res.read_glyph;
   assign rsp_cursor_col = out_res.cursor_col;
   assign rsp_cursor_row = out_res.cursor_row;
   assign rsp_did_scroll = out_res.did_scroll;

endmodule

// ===== rtl/tccs_checker.sv =====
// ----------------------------------------------------------------------------
// Text console checker
// Port-level properties of the console, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_macros.svh"

module tccs_checker import tccs_pkg::*; #(
   parameter int ROWS = DEF_ROWS
) (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_read_glyph,
   input logic [4:0] rsp_cursor_col,
   input logic [4:0] rsp_cursor_row,
   input logic       rsp_did_scroll
);

   localparam logic [4:0] ROW_LAST5 = 5'(ROWS - 1);

   // A waiting response holds until it is taken
   `TCCS_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_read_glyph) && $stable(rsp_cursor_col)
      && $stable(rsp_cursor_row) && $stable(rsp_did_scroll),
      "response changed while waiting")

   // A scroll leaves the cursor at the start of the last row
   `TCCS_ASSERT_NOW(a_scroll_cursor, clock, reset, !empty && rsp_did_scroll,
      rsp_cursor_col == 5'd0 && rsp_cursor_row == ROW_LAST5,
      "scroll left cursor off the last row start")

   // A scrolling transaction is never a read
   `TCCS_ASSERT_NOW(a_scroll_no_read, clock, reset, !empty && rsp_did_scroll,
      rsp_read_glyph == 8'd0, "scroll response carries read data")

   // The cursor row never passes the bottom of the screen
   `TCCS_ASSERT_NOW(a_row_range, clock, reset, !empty && (ROWS <= 32),
      rsp_cursor_row <= ROW_LAST5, "cursor row beyond screen")

endmodule

bind text_console_cursor_scroll tccs_checker #(.ROWS(ROWS)) u_tccs_checker (.*);
